// ===== rtl/core/pau_pkg.sv =====
// Shared types and constants for the Pareto archive update unit.
package pau_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int NUM_OBJ      = 4;
    localparam int OBJ_W        = 32;
    localparam int TAG_W        = 16;
    localparam int IDX_W        = 5;
    localparam int CNT_OUT_W    = 6;
    localparam int ENTRY_W      = NUM_OBJ * OBJ_W + OBJ_W + TAG_W;
    localparam int IN_DATA_W    = 184;
    localparam int OUT_DATA_W   = 192;
    localparam int USED_W       = 3;

    localparam logic [USED_W-1:0] OBJ_USED_RST = 3'd4;
    localparam logic              REG_OBJ_USED = 1'b0;

    typedef enum logic {
        MODE_INSERT = 1'b0,
        MODE_READ   = 1'b1
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_READ_WAIT,
        ST_SCAN,
        ST_APPEND,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [TAG_W-1:0]              tag;
        logic [OBJ_W-1:0]              viol;
        logic [NUM_OBJ-1:0][OBJ_W-1:0] obj;
    } t_entry;

    typedef struct packed {
        logic                          valid;
        logic [TAG_W-1:0]              tag;
        logic [OBJ_W-1:0]              viol;
        logic [NUM_OBJ-1:0][OBJ_W-1:0] obj;
        logic [CNT_OUT_W-1:0]          size;
        logic [CNT_OUT_W-1:0]          removed;
        logic                          dropped;
        logic                          accepted;
    } t_result;

endpackage

// ===== rtl/core/pau_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module pau_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/pareto_archive_update_unit.sv =====
// Pareto archive update unit: constrained non-dominated archive with read access.
//
// The archive lives in one RAM read one entry per cycle. An insert streams every
// stored entry through a single dominance compare unit, rewriting the kept entries
// in place behind the read pointer, then appends the candidate unless it was
// rejected or the archive is full. The rate is set by the one RAM read port and
// the shared compare unit. Input is not ready while an item is in work; a
// finished result waits in an output register so the next item may be taken
// before it is drained. Entries are valid only below the stored count, so no
// clearing happens after reset.
module pareto_archive_update_unit #(
    parameter int CAPACITY = pau_pkg::CAPACITY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // s_axis_tdata: read_index[4:0], obj_0[36:5], obj_1[68:37], obj_2[100:69],
    //               obj_3[132:101], violation[164:133], payload_tag[180:165], zero fill
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [pau_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // s_axis_tuser: mode[0]
    input  logic [0:0]                     s_axis_tuser,
    // m_axis_tdata: accepted[0], dropped_full[1], removed_count[7:2],
    //               archive_size[13:8], entry_obj_0[45:14], entry_obj_1[77:46],
    //               entry_obj_2[109:78], entry_obj_3[141:110],
    //               entry_violation[173:142], entry_tag[189:174],
    //               entry_valid[190], zero fill
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [pau_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [2:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int NO = pau_pkg::NUM_OBJ;
    localparam int OW = pau_pkg::OBJ_W;

    // configuration
    logic [pau_pkg::USED_W-1:0] r_obj_used;
    logic [pau_pkg::USED_W-1:0] used_n;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == pau_pkg::REG_OBJ_USED)
                  ? {{(32 - pau_pkg::USED_W){1'b0}}, r_obj_used} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_obj_used <= pau_pkg::OBJ_USED_RST;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == pau_pkg::REG_OBJ_USED) begin
            r_obj_used <= pwdata[pau_pkg::USED_W-1:0];
        end
    end

    always_comb begin
        if (r_obj_used == '0) begin
            used_n = pau_pkg::USED_W'(1);
        end else if (32'(r_obj_used) > NO) begin
            used_n = pau_pkg::USED_W'(NO);
        end else begin
            used_n = r_obj_used;
        end
    end

    // control and payload registers
    pau_pkg::t_state  r_state, n_state;
    logic [pau_pkg::IDX_W-1:0] r_ridx, n_ridx;
    pau_pkg::t_entry  r_cand, n_cand;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_rd_idx, n_rd_idx;
    logic [CW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [CW-1:0]    r_removed, n_removed;
    logic             r_pipe_vld, n_pipe_vld;
    logic             r_rejected, n_rejected;
    pau_pkg::t_result r_res, n_res;
    logic             r_out_valid, n_out_valid;
    pau_pkg::t_result r_out, n_out;

    // RAM port
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    pau_pkg::t_entry  ram_wdata;
    logic             ram_re;
    logic [AW-1:0]    ram_raddr;
    pau_pkg::t_entry  ram_q;

    pau_ram #(
        .WIDTH (pau_pkg::ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    // shared dominance compare: stored entry against candidate
    logic [NO-1:0] e_lt, e_gt;
    logic          e_inf, c_inf, e_ge_c_viol, c_ge_e_viol;
    logic          dom_remove, dom_reject;

    always_comb begin
        for (int k = 0; k < NO; k++) begin
            e_lt[k] = (pau_pkg::USED_W'(k) < used_n)
                    && ($signed(ram_q.obj[k]) < $signed(r_cand.obj[k]));
            e_gt[k] = (pau_pkg::USED_W'(k) < used_n)
                    && ($signed(ram_q.obj[k]) > $signed(r_cand.obj[k]));
        end
        e_inf       = $signed(ram_q.viol) > 0;
        c_inf       = $signed(r_cand.viol) > 0;
        e_ge_c_viol = $signed(ram_q.viol) >= $signed(r_cand.viol);
        c_ge_e_viol = $signed(r_cand.viol) >= $signed(ram_q.viol);
        dom_remove  = (e_inf && !c_inf)
                    || (e_inf && c_inf && e_ge_c_viol)
                    || (!e_inf && !c_inf && (e_lt == '0) && (e_gt != '0));
        dom_reject  = (c_inf && !e_inf)
                    || (e_inf && c_inf && c_ge_e_viol)
                    || (!e_inf && !c_inf && (e_gt == '0) && (e_lt != '0))
                    || ((e_lt == '0) && (e_gt == '0));
    end

    logic [31:0] ridx_wide;
    logic        read_hit;

    assign ridx_wide     = 32'(r_ridx);
    assign read_hit      = 32'(r_count) > ridx_wide;
    assign s_axis_tready = (r_state == pau_pkg::ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pau_pkg::ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ridx     <= n_ridx;
        r_cand     <= n_cand;
        r_rd_idx   <= n_rd_idx;
        r_wr_ptr   <= n_wr_ptr;
        r_removed  <= n_removed;
        r_pipe_vld <= n_pipe_vld;
        r_rejected <= n_rejected;
        r_res      <= n_res;
        r_out      <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_ridx      = r_ridx;
        n_cand      = r_cand;
        n_count     = r_count;
        n_rd_idx    = r_rd_idx;
        n_wr_ptr    = r_wr_ptr;
        n_removed   = r_removed;
        n_pipe_vld  = r_pipe_vld;
        n_rejected  = r_rejected;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        ram_we      = 1'b0;
        ram_waddr   = r_wr_ptr[AW-1:0];
        ram_wdata   = ram_q;
        ram_re      = 1'b0;
        ram_raddr   = r_rd_idx[AW-1:0];

        // drain the output register
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            pau_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_ridx          = s_axis_tdata[4:0];
                    n_cand.obj[0]   = s_axis_tdata[36:5];
                    n_cand.obj[1]   = s_axis_tdata[68:37];
                    n_cand.obj[2]   = s_axis_tdata[100:69];
                    n_cand.obj[3]   = s_axis_tdata[132:101];
                    n_cand.viol     = s_axis_tdata[164:133];
                    n_cand.tag      = s_axis_tdata[180:165];
                    n_rd_idx        = '0;
                    n_wr_ptr        = '0;
                    n_removed       = '0;
                    n_pipe_vld      = 1'b0;
                    n_rejected      = 1'b0;
                    n_state         = (pau_pkg::t_mode'(s_axis_tuser[0]) == pau_pkg::MODE_READ)
                                    ? pau_pkg::ST_READ : pau_pkg::ST_SCAN;
                end
            end
            pau_pkg::ST_READ: begin
                ram_re    = read_hit;
                ram_raddr = ridx_wide[AW-1:0];
                n_state   = pau_pkg::ST_READ_WAIT;
            end
            pau_pkg::ST_READ_WAIT: begin
                n_res          = '0;
                n_res.size     = pau_pkg::CNT_OUT_W'(r_count);
                if (read_hit) begin
                    n_res.obj   = ram_q.obj;
                    n_res.viol  = ram_q.viol;
                    n_res.tag   = ram_q.tag;
                    n_res.valid = 1'b1;
                end
                n_state = pau_pkg::ST_DONE;
            end
            pau_pkg::ST_SCAN: begin
                // issue the next read while the previous entry is judged
                if (r_rd_idx < r_count) begin
                    ram_re     = 1'b1;
                    n_rd_idx   = r_rd_idx + 1'b1;
                    n_pipe_vld = 1'b1;
                end else begin
                    n_pipe_vld = 1'b0;
                end
                if (r_pipe_vld) begin
                    if (dom_remove) begin
                        n_removed = r_removed + 1'b1;
                    end else begin
                        if (dom_reject) begin
                            n_rejected = 1'b1;
                        end
                        // compact kept entries behind the read pointer
                        ram_we   = 1'b1;
                        n_wr_ptr = r_wr_ptr + 1'b1;
                    end
                end else if (r_rd_idx >= r_count) begin
                    n_state = pau_pkg::ST_APPEND;
                end
            end
            pau_pkg::ST_APPEND: begin
                n_res         = '0;
                n_res.removed = pau_pkg::CNT_OUT_W'(r_removed);
                n_count       = r_wr_ptr;
                if (!r_rejected) begin
                    if (32'(r_wr_ptr) < CAPACITY) begin
                        ram_we         = 1'b1;
                        ram_wdata      = r_cand;
                        n_count        = CW'(r_wr_ptr + 1'b1);
                        n_res.accepted = 1'b1;
                    end else begin
                        n_res.dropped  = 1'b1;
                    end
                end
                n_res.size = pau_pkg::CNT_OUT_W'(n_count);
                n_state    = pau_pkg::ST_DONE;
            end
            pau_pkg::ST_DONE: begin
                // hold until the output register has room
                if (!r_out_valid || m_axis_tready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = pau_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pau_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out};

    // assertions
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= CAPACITY)
        else $error("archive count exceeds capacity");

    a_scan_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pau_pkg::ST_SCAN) |->
            (32'(r_wr_ptr) + 32'(r_removed) + 32'(r_pipe_vld) == 32'(r_rd_idx)))
        else $error("scan pointers out of balance");

    a_write_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pau_pkg::ST_SCAN && ram_we && ram_re) |->
            (r_wr_ptr < r_rd_idx))
        else $error("compaction write overtook read pointer");

    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.accepted && r_out.dropped))
        else $error("accepted and dropped both set");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != pau_pkg::ST_APPEND) |=> $stable(r_count))
        else $error("archive count changed outside append");

endmodule
